// ===== rtl/bws_pkg.sv =====
// Shared types and constants for the bilinear wrap sampler.
// No dependencies; imported by bws_addr, bws_lane and the top level.
package bws_pkg;

  localparam int unsigned LANES   = 4;
  localparam int unsigned CH_W    = 16;
  localparam int unsigned FRAC_W  = 15;
  localparam int unsigned OUT_W   = 15;
  localparam int unsigned PIXEL_W = LANES * CH_W;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned CFG_W   = 3;
  localparam int unsigned CFGA_W  = 2;
  localparam logic [CH_W-1:0] BIAS = 16'h8000;

  localparam logic [CFGA_W-1:0] CFG_WIDTH_LOG2  = 2'd0;
  localparam logic [CFGA_W-1:0] CFG_HEIGHT_LOG2 = 2'd1;

  typedef enum logic [0:0] {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  // One channel of the four neighbours: p<x><y>
  typedef struct packed {
    logic [CH_W-1:0] p00;
    logic [CH_W-1:0] p10;
    logic [CH_W-1:0] p01;
    logic [CH_W-1:0] p11;
  } quad_t;

  typedef struct packed {
    logic [FRAC_W-1:0] fu;
    logic [FRAC_W-1:0] fv;
  } frac_t;

endpackage

// ===== rtl/bws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bws_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bws_addr.sv =====
// Wrapped neighbour address and fraction generation for one sample.
// Depends on bws_pkg.
module bws_addr #(
  parameter int unsigned MW = 6,
  parameter int unsigned MH = 6
) (
  input  logic [31:0]              coord_u_i,
  input  logic [31:0]              coord_v_i,
  input  logic [bws_pkg::CFG_W-1:0] wl_i,
  input  logic [bws_pkg::CFG_W-1:0] hl_i,
  output logic [MW+MH-1:0]         a00_o,
  output logic [MW+MH-1:0]         a10_o,
  output logic [MW+MH-1:0]         a01_o,
  output logic [MW+MH-1:0]         a11_o,
  output bws_pkg::frac_t           frac_o
);
  import bws_pkg::*;

  localparam int unsigned AW = MW + MH;

  logic [MW-1:0] xmask, x0, x1;
  logic [MH-1:0] ymask, y0, y1;
  logic [AW-1:0] row0, row1;

  always_comb begin
    xmask = ~({MW{1'b1}} << wl_i);
    ymask = ~({MH{1'b1}} << hl_i);
    x0    = coord_u_i[16 +: MW] & xmask;
    y0    = coord_v_i[16 +: MH] & ymask;
    x1    = (x0 + MW'(1)) & xmask;
    y1    = (y0 + MH'(1)) & ymask;
    row0  = AW'(y0) << wl_i;
    row1  = AW'(y1) << wl_i;
    a00_o = row0 | AW'(x0);
    a10_o = row0 | AW'(x1);
    a01_o = row1 | AW'(x0);
    a11_o = row1 | AW'(x1);
    frac_o.fu = coord_u_i[15:1];
    frac_o.fv = coord_v_i[15:1];
  end

endmodule

// ===== rtl/bws_lane.sv =====
// One channel lane: horizontal then vertical interpolation, two multiplier stages.
// Depends on bws_pkg.
module bws_lane (
  input  logic                       clk_i,
  input  bws_pkg::quad_t             quad_i,
  input  logic [bws_pkg::FRAC_W-1:0] fu_i,
  input  logic [bws_pkg::FRAC_W-1:0] fv_i,
  output logic [bws_pkg::OUT_W-1:0]  result_o
);
  import bws_pkg::*;

  logic [CH_W-1:0]          dtop, dbot;
  logic signed [2*CH_W-1:0] prod_top_d, prod_bot_d, prod_top_q, prod_bot_q;
  logic [CH_W-1:0]          top_q, bot_q;
  logic [CH_W-1:0]          h0, h1, dv;
  logic signed [2*CH_W-1:0] prod_v_d, prod_v_q;
  logic [CH_W-1:0]          h0b_d, h0b_q;
  logic [CH_W-1:0]          biased;

  // Horizontal deltas wrap at 16 bits, fractions are non-negative
  always_comb begin
    dtop       = quad_i.p10 - quad_i.p00;
    dbot       = quad_i.p11 - quad_i.p01;
    prod_top_d = $signed(dtop) * $signed({1'b0, fu_i});
    prod_bot_d = $signed(dbot) * $signed({1'b0, fu_i});
  end

  always_ff @(posedge clk_i) begin
    prod_top_q <= prod_top_d;
    prod_bot_q <= prod_bot_d;
    top_q      <= quad_i.p00;
    bot_q      <= quad_i.p01;
  end

  // Floor of product / 2^16, doubled: bits 30..16 shifted up by one
  always_comb begin
    h0       = top_q + {prod_top_q[30:16], 1'b0};
    h1       = bot_q + {prod_bot_q[30:16], 1'b0};
    dv       = h1 - h0;
    prod_v_d = $signed(dv) * $signed({1'b0, fv_i});
    h0b_d    = h0 + BIAS;
  end

  always_ff @(posedge clk_i) begin
    prod_v_q <= prod_v_d;
    h0b_q    <= h0b_d;
  end

  always_comb begin
    biased   = h0b_q + {prod_v_q[30:16], 1'b0};
    result_o = biased[CH_W-1] ? biased[OUT_W-1:0] : '0;
  end

endmodule

// ===== rtl/bilinear_wrap_sampler_top.sv =====
// Top level of the bilinear wrap sampler: image store, address stage, lanes, merge.
// Depends on bws_pkg, bws_ram, bws_addr and bws_lane.
//
// The block takes one word per clock, a pixel write or a sample, and never
// raises busy. A sample's result appears on the sample ports, marked by
// sample_valid_o, after the registered store read, which captures at the
// accepting edge, the two multiplier stages in each lane and the output
// register. Results arrive in the order of acceptance and the receiver
// cannot hold them off. Writes give no result. The image is kept in four
// identical copies so the four neighbours of a sample are read together;
// a write lands in all four and is seen by any sample accepted after it.
// Store contents are undefined until written: sample only pixels that
// have been written. Size registers above the maximum saturate to it.
module bilinear_wrap_sampler_top #(
  parameter int unsigned MAX_WIDTH_LOG2  = 6,
  parameter int unsigned MAX_HEIGHT_LOG2 = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        command_i,
  input  logic [bws_pkg::IDX_W-1:0]   pixel_index_i,
  input  logic [bws_pkg::CH_W-1:0]    write_word0_i,
  input  logic [bws_pkg::CH_W-1:0]    write_word1_i,
  input  logic [bws_pkg::CH_W-1:0]    write_word2_i,
  input  logic [bws_pkg::CH_W-1:0]    write_word3_i,
  input  logic [31:0]                 coord_u_i,
  input  logic [31:0]                 coord_v_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bws_pkg::CFGA_W-1:0]  cfg_index_i,
  input  logic [bws_pkg::CFG_W-1:0]   cfg_data_i,
  output logic                        sample_valid_o,
  output logic [bws_pkg::OUT_W-1:0]   sample_word0_o,
  output logic [bws_pkg::OUT_W-1:0]   sample_word1_o,
  output logic [bws_pkg::OUT_W-1:0]   sample_word2_o,
  output logic [bws_pkg::OUT_W-1:0]   sample_word3_o
);
  import bws_pkg::*;

  localparam int unsigned AW    = MAX_WIDTH_LOG2 + MAX_HEIGHT_LOG2;
  localparam int unsigned DEPTH = 1 << AW;
  // Largest size value that the 3-bit register can actually take
  localparam int unsigned WCAP  = MAX_WIDTH_LOG2 > 7 ? 7 : MAX_WIDTH_LOG2;
  localparam int unsigned HCAP  = MAX_HEIGHT_LOG2 > 7 ? 7 : MAX_HEIGHT_LOG2;
  localparam int unsigned WRST  = WCAP < 6 ? WCAP : 6;
  localparam int unsigned HRST  = HCAP < 6 ? HCAP : 6;

  logic accept, wr_acc, smp_acc;
  logic [CFG_W-1:0] wl_q, wl_d, hl_q, hl_d;

  // Never stall: a word can enter every cycle
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign wr_acc      = accept && (command_i == CMD_WRITE);
  assign smp_acc     = accept && (command_i == CMD_SAMPLE);

  // Size registers, saturated on write; unknown indexes drop
  always_comb begin
    wl_d = wl_q;
    hl_d = hl_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_WIDTH_LOG2: begin
          wl_d = (cfg_data_i > CFG_W'(WCAP)) ? CFG_W'(WCAP) : cfg_data_i;
        end
        CFG_HEIGHT_LOG2: begin
          hl_d = (cfg_data_i > CFG_W'(HCAP)) ? CFG_W'(HCAP) : cfg_data_i;
        end
        default: begin
          wl_d = wl_q;
          hl_d = hl_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= CFG_W'(WRST);
      hl_q <= CFG_W'(HRST);
    end else begin
      wl_q <= wl_d;
      hl_q <= hl_d;
    end
  end

  // Address stage: wrapped neighbours, computed as the word is accepted
  logic [AW-1:0] raddr [4];
  frac_t         frac;

  bws_addr #(
    .MW (MAX_WIDTH_LOG2),
    .MH (MAX_HEIGHT_LOG2)
  ) u_addr (
    .coord_u_i (coord_u_i),
    .coord_v_i (coord_v_i),
    .wl_i      (wl_q),
    .hl_i      (hl_q),
    .a00_o     (raddr[0]),
    .a10_o     (raddr[1]),
    .a01_o     (raddr[2]),
    .a11_o     (raddr[3]),
    .frac_o    (frac)
  );

  // Four copies of the image, one per neighbour; channel 0 in the low bits
  logic [PIXEL_W-1:0] wdata;
  logic [AW-1:0]      waddr;
  logic [PIXEL_W-1:0] rdata [4];

  assign wdata = {write_word3_i, write_word2_i, write_word1_i, write_word0_i};
  assign waddr = AW'(pixel_index_i);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    bws_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr_acc),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .re_i    (smp_acc),
      .raddr_i (raddr[b]),
      .rdata_o (rdata[b])
    );
  end

  // Valid pipeline and fraction alignment
  logic              v0_q, v1_q, v2_q, strobe_q;
  logic [FRAC_W-1:0] fu_q, fv0_q, fv1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q     <= 1'b0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      v0_q     <= smp_acc;
      v1_q     <= v0_q;
      v2_q     <= v1_q;
      strobe_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      fu_q  <= frac.fu;
      fv0_q <= frac.fv;
    end
    fv1_q <= fv0_q;
  end

  // One lane per channel
  logic [OUT_W-1:0] lane_res [LANES];

  for (genvar c = 0; c < LANES; c++) begin : g_lane
    quad_t quad;
    assign quad.p00 = rdata[0][c*CH_W +: CH_W];
    assign quad.p10 = rdata[1][c*CH_W +: CH_W];
    assign quad.p01 = rdata[2][c*CH_W +: CH_W];
    assign quad.p11 = rdata[3][c*CH_W +: CH_W];

    bws_lane u_lane (
      .clk_i    (clk_i),
      .quad_i   (quad),
      .fu_i     (fu_q),
      .fv_i     (fv1_q),
      .result_o (lane_res[c])
    );
  end

  // Merge: gather the lanes into one result word
  logic [OUT_W-1:0] res_q [LANES];

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      for (int c = 0; c < LANES; c++) begin
        res_q[c] <= lane_res[c];
      end
    end
  end

  assign sample_valid_o = strobe_q;
  assign sample_word0_o = res_q[0];
  assign sample_word1_o = res_q[1];
  assign sample_word2_o = res_q[2];
  assign sample_word3_o = res_q[3];

`ifndef SYNTHESIS
  a_result_from_sample : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_o |-> $past(smp_acc, 4))
    else $error("result without a sample four cycles before");

  a_write_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_acc |-> ##4 !sample_valid_o)
    else $error("write produced a result");

  a_sample_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_acc |-> ##4 sample_valid_o)
    else $error("sample lost in pipeline");

  a_size_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wl_q <= CFG_W'(WCAP)) && (hl_q <= CFG_W'(HCAP)))
    else $error("size register beyond maximum");
`endif

endmodule

// ===== tb/tb_bilinear_wrap_sampler_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for bilinear_wrap_sampler_top: drives pixel writes and samples,
// predicts every interpolated pixel and checks it. Depends on bws_pkg and the RTL.

module tb_bilinear_wrap_sampler_top;
  import bws_pkg::*;

  localparam int unsigned MAX_W_LOG2  = 6;
  localparam int unsigned MAX_H_LOG2  = 6;
  localparam int unsigned DEPTH       = 1 << (MAX_W_LOG2 + MAX_H_LOG2);
  // Store read, two multiplier stages and the output register.
  localparam int unsigned PIPE_DEPTH  = 4;
  localparam int unsigned SETTLE      = 2 * PIPE_DEPTH;
  localparam int unsigned WORD_TARGET = 1500;
  localparam int unsigned PHASES      = 8;

  // Register indexes that the block does not decode.
  localparam logic [CFGA_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFGA_W-1:0] CFG_SPARE_B = 2'd3;

  // Four output channels, channel 0 in lane 0.
  typedef logic [LANES-1:0][OUT_W-1:0] sample_t;
  // Store addresses of the neighbours in the order p00, p10, p01, p11.
  typedef logic [3:0][IDX_W-1:0] quad_addr_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               start          = 1'b0;
  logic               busy;
  logic               command_i      = CMD_WRITE;
  logic [IDX_W-1:0]   pixel_index_i  = '0;
  logic [CH_W-1:0]    write_word0_i  = '0;
  logic [CH_W-1:0]    write_word1_i  = '0;
  logic [CH_W-1:0]    write_word2_i  = '0;
  logic [CH_W-1:0]    write_word3_i  = '0;
  logic [31:0]        coord_u_i      = '0;
  logic [31:0]        coord_v_i      = '0;
  logic               cfg_valid_i    = 1'b0;
  logic               cfg_ready_o;
  logic [CFGA_W-1:0]  cfg_index_i    = CFG_WIDTH_LOG2;
  logic [CFG_W-1:0]   cfg_data_i     = '0;
  logic               sample_valid_o;
  logic [OUT_W-1:0]   sample_word0_o;
  logic [OUT_W-1:0]   sample_word1_o;
  logic [OUT_W-1:0]   sample_word2_o;
  logic [OUT_W-1:0]   sample_word3_o;

  always #5 clk_i = ~clk_i;

  bilinear_wrap_sampler_top #(
    .MAX_WIDTH_LOG2  (MAX_W_LOG2),
    .MAX_HEIGHT_LOG2 (MAX_H_LOG2)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .pixel_index_i  (pixel_index_i),
    .write_word0_i  (write_word0_i),
    .write_word1_i  (write_word1_i),
    .write_word2_i  (write_word2_i),
    .write_word3_i  (write_word3_i),
    .coord_u_i      (coord_u_i),
    .coord_v_i      (coord_v_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .sample_valid_o (sample_valid_o),
    .sample_word0_o (sample_word0_o),
    .sample_word1_o (sample_word1_o),
    .sample_word2_o (sample_word2_o),
    .sample_word3_o (sample_word3_o)
  );

  // ---------------------------------------------------------------------------
  // Mirror of the block: image contents, which entries hold data, and the
  // size registers as the block sees them (already saturated).
  // ---------------------------------------------------------------------------
  logic [PIXEL_W-1:0] texel_mirror [DEPTH];
  bit                 texel_written [DEPTH];
  int unsigned        width_sel  = MAX_W_LOG2;
  int unsigned        height_sel = MAX_H_LOG2;

  sample_t            pending_samples [$];
  int unsigned        n_errors = 0;
  int unsigned        n_sent   = 0;
  bit                 gaps_on  = 1'b1;

  // Wrap the integer parts to the image and form the four store addresses.
  function automatic quad_addr_t neighbour_addrs(input logic [31:0] u, input logic [31:0] v);
    logic [31:0] xmask, ymask, x0, y0, x1, y1;
    quad_addr_t  a;
    xmask = (32'd1 << width_sel) - 32'd1;
    ymask = (32'd1 << height_sel) - 32'd1;
    x0 = {16'd0, u[31:16]} & xmask;
    y0 = {16'd0, v[31:16]} & ymask;
    x1 = (x0 + 32'd1) & xmask;
    y1 = (y0 + 32'd1) & ymask;
    a[0] = IDX_W'((y0 << width_sel) | x0);
    a[1] = IDX_W'((y0 << width_sel) | x1);
    a[2] = IDX_W'((y1 << width_sel) | x0);
    a[3] = IDX_W'((y1 << width_sel) | x1);
    return a;
  endfunction

  // Advance base by twice the floored high half of delta * frac, wrapping at
  // 16 bits. Delta is a two's complement step, frac a 15-bit fraction.
  function automatic logic [CH_W-1:0] lerp_step(input logic [CH_W-1:0] base,
                                                 input logic [CH_W-1:0] delta,
                                                 input logic [FRAC_W-1:0] frac);
    int          d_s;
    int          f_s;
    int          hi;
    logic [31:0] sum;
    d_s = $signed(delta);
    f_s = frac;
    // Arithmetic shift floors negative products as well.
    hi  = (d_s * f_s) >>> 16;
    sum = base + 2 * hi;
    return sum[CH_W-1:0];
  endfunction

  // Expected pixel for a sample at (u, v) under the current image and sizes.
  function automatic sample_t bilinear_predict(input logic [31:0] u, input logic [31:0] v);
    quad_addr_t         a;
    logic [PIXEL_W-1:0] p00, p10, p01, p11;
    logic [CH_W-1:0]    top, bot, h0, h1, biased;
    logic [FRAC_W-1:0]  fu, fv;
    sample_t            r;
    a   = neighbour_addrs(u, v);
    p00 = texel_mirror[a[0]];
    p10 = texel_mirror[a[1]];
    p01 = texel_mirror[a[2]];
    p11 = texel_mirror[a[3]];
    fu  = u[15:1];
    fv  = v[15:1];
    for (int c = 0; c < LANES; c++) begin
      top = p00[c*CH_W +: CH_W];
      bot = p01[c*CH_W +: CH_W];
      // Horizontal pass on both rows, then the vertical pass with the bias.
      h0  = lerp_step(top, p10[c*CH_W +: CH_W] - top, fu);
      h1  = lerp_step(bot, p11[c*CH_W +: CH_W] - bot, fu);
      biased = lerp_step(h0 + BIAS, h1 - h0, fv);
      r[c] = (biased < BIAS) ? '0 : OUT_W'(biased - BIAS);
    end
    return r;
  endfunction

  // Channel values biased towards the corners of the range, so the clamp
  // and the wrapping deltas are hit often.
  function automatic logic [PIXEL_W-1:0] rand_pixel();
    logic [PIXEL_W-1:0] px;
    case ($urandom_range(7))
      0: px = '0;
      1: px = '1;
      default: begin
        for (int c = 0; c < LANES; c++) begin
          case ($urandom_range(5))
            0:       px[c*CH_W +: CH_W] = 16'h0000;
            1:       px[c*CH_W +: CH_W] = 16'hffff;
            2:       px[c*CH_W +: CH_W] = 16'h8000;
            3:       px[c*CH_W +: CH_W] = 16'h7fff;
            default: px[c*CH_W +: CH_W] = CH_W'($urandom);
          endcase
        end
      end
    endcase
    return px;
  endfunction

  // A 16.16 coordinate whose integer part often sits on the wrap edge of
  // an image of 2**size_log2 pixels, and whose fraction often sits at 0 or 1.
  function automatic logic [31:0] rand_coord(input int unsigned size_log2);
    logic [15:0] whole, frac;
    case ($urandom_range(3))
      0:       whole = 16'($urandom);
      1:       whole = 16'($urandom) | 16'((32'd1 << size_log2) - 32'd1);
      2:       whole = 16'h0000;
      default: whole = 16'hffff;
    endcase
    case ($urandom_range(4))
      0:       frac = 16'h0000;
      1:       frac = 16'hffff;
      2:       frac = 16'h0001;
      default: frac = 16'($urandom);
    endcase
    return {whole, frac};
  endfunction

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------

  // Offer one word and hold it until accepted; start stays high on return so
  // back-to-back words need no extra edge. Update the mirror on acceptance.
  task automatic send_item(input cmd_e cmd, input logic [IDX_W-1:0] idx,
                           input logic [PIXEL_W-1:0] px,
                           input logic [31:0] u, input logic [31:0] v);
    if (gaps_on && $urandom_range(99) < 15) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    command_i     <= cmd;
    pixel_index_i <= idx;
    write_word0_i <= px[0*CH_W +: CH_W];
    write_word1_i <= px[1*CH_W +: CH_W];
    write_word2_i <= px[2*CH_W +: CH_W];
    write_word3_i <= px[3*CH_W +: CH_W];
    coord_u_i     <= u;
    coord_v_i     <= v;
    start         <= 1'b1;
    do @(posedge clk_i); while (busy);
    n_sent++;
    if (cmd == CMD_WRITE) begin
      texel_mirror[idx]  = px;
      texel_written[idx] = 1'b1;
    end else begin
      pending_samples.push_back(bilinear_predict(u, v));
    end
  endtask

  task automatic write_pixel(input logic [IDX_W-1:0] idx, input logic [PIXEL_W-1:0] px);
    send_item(CMD_WRITE, idx, px, $urandom, $urandom);
  endtask

  // Fill any neighbour that was never written, then sample: the store has no
  // defined contents until written.
  task automatic sample_at(input logic [31:0] u, input logic [31:0] v);
    quad_addr_t a;
    a = neighbour_addrs(u, v);
    for (int k = 0; k < 4; k++) begin
      if (!texel_written[a[k]]) write_pixel(a[k], rand_pixel());
    end
    send_item(CMD_SAMPLE, IDX_W'($urandom), {$urandom, $urandom}, u, v);
  endtask

  // Drop start, wait for every outstanding sample, then let the pipeline
  // settle so a register write cannot overtake a word still in flight.
  task automatic drain();
    int unsigned waited;
    start  <= 1'b0;
    waited = 0;
    while (pending_samples.size() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_samples.size() != 0) begin
      $display("%0t: %0d expected samples never arrived", $time, pending_samples.size());
      n_errors += pending_samples.size();
      pending_samples.delete();
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Register side
  // ---------------------------------------------------------------------------

  // Hold one register word until taken; valid is left high for the caller.
  task automatic cfg_word(input logic [CFGA_W-1:0] idx, input logic [CFG_W-1:0] data);
    int unsigned sat;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_WIDTH_LOG2: begin
        sat = data;
        width_sel = (sat > MAX_W_LOG2) ? MAX_W_LOG2 : sat;
      end
      CFG_HEIGHT_LOG2: begin
        sat = data;
        height_sel = (sat > MAX_H_LOG2) ? MAX_H_LOG2 : sat;
      end
      default: ;
    endcase
  endtask

  // Set both sizes; optionally follow with words to the undecoded indexes,
  // which must leave the sizes alone.
  task automatic program_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input bit with_spare);
    cfg_word(CFG_WIDTH_LOG2, w);
    cfg_word(CFG_HEIGHT_LOG2, h);
    if (with_spare) begin
      cfg_word(CFG_SPARE_A, CFG_W'($urandom));
      cfg_word(CFG_SPARE_B, CFG_W'($urandom));
    end
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: the receiver cannot stall, so take every strobed word.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    sample_t got;
    sample_t want;
    if (rst_ni && sample_valid_o) begin
      got = {sample_word3_o, sample_word2_o, sample_word1_o, sample_word0_o};
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample word %h", $time, got);
        n_errors++;
      end else begin
        want = pending_samples.pop_front();
        for (int c = 0; c < LANES; c++) begin
          if (got[c] !== want[c]) begin
            $display("%0t: sample_word%0d expected %h actual %h", $time, c, want[c], got[c]);
            n_errors++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset sizes are the maxima: sample across both wrap edges of a 64x64
  // image without touching the registers.
  task automatic test_default_size();
    write_pixel(12'd4095, {16'hffff, 16'h0000, 16'h8000, 16'h7fff});
    write_pixel(12'd4032, {16'h0000, 16'hffff, 16'h7fff, 16'h8000});
    write_pixel(12'd63,   {16'h8000, 16'h7fff, 16'hffff, 16'h0000});
    write_pixel(12'd0,    {16'h7fff, 16'h8000, 16'h0000, 16'hffff});
    // Integer parts of all ones wrap to the last column and row.
    sample_at(32'hffff_ffff, 32'hffff_ffff);
    sample_at(32'h003f_8000, 32'h003f_0000);
    sample_at(32'h0000_0000, 32'h0000_0000);
    drain();
  endtask

  // A 2x2 image with corner channel values and fractions at 0, half and max.
  task automatic test_value_extremes();
    program_size(3'd1, 3'd1, 1'b0);
    write_pixel(12'd0, {16'hffff, 16'h0000, 16'h8000, 16'h7fff});
    write_pixel(12'd1, {16'h0000, 16'hffff, 16'h7fff, 16'h8000});
    write_pixel(12'd2, '1);
    write_pixel(12'd3, '0);
    sample_at(32'h0000_0000, 32'h0000_ffff);
    sample_at(32'h0000_ffff, 32'h0000_0000);
    sample_at(32'h0001_8000, 32'h0001_8000);
    sample_at(32'hffff_ffff, 32'h8000_0001);
    drain();
  endtask

  // Smallest image (all four neighbours are one pixel), then oversized
  // values that saturate, then undecoded indexes that change nothing.
  task automatic test_size_extremes();
    program_size(3'd0, 3'd0, 1'b0);
    write_pixel(12'd0, {16'h1234, 16'hfedc, 16'h8000, 16'h0001});
    sample_at(32'habcd_7fff, 32'h1234_ffff);
    drain();
    program_size(3'd7, 3'd7, 1'b1);
    write_pixel(12'd4095, rand_pixel());
    sample_at(32'h007f_4000, 32'h00bf_c000);
    drain();
    program_size(3'd0, 3'd6, 1'b1);
    sample_at(32'h0000_ffff, 32'h003f_ffff);
    drain();
  endtask

  // Random traffic under several sizes. Most words are samples with their
  // neighbours filled first; the rest are writes anywhere in the store.
  task automatic test_random_traffic();
    logic [CFG_W-1:0] plan_w [PHASES];
    logic [CFG_W-1:0] plan_h [PHASES];
    int unsigned      phase_end;
    plan_w = '{3'd6, 3'd0, 3'd3, 3'd7, 3'd2, 3'd5, 3'd1, 3'd4};
    plan_h = '{3'd6, 3'd3, 3'd0, 3'd7, 3'd5, 3'd2, 3'd1, 3'd4};
    for (int p = 0; p < PHASES; p++) begin
      // Last phase picks a fresh setting each run.
      if (p == PHASES - 1) begin
        plan_w[p] = CFG_W'($urandom);
        plan_h[p] = CFG_W'($urandom);
      end
      program_size(plan_w[p], plan_h[p], p[0]);
      // Keep one phase entirely free of gaps.
      gaps_on   = (p != 3);
      phase_end = n_sent + WORD_TARGET / PHASES;
      while (n_sent < phase_end) begin
        if ($urandom_range(99) < 75)
          sample_at(rand_coord(width_sel), rand_coord(height_sel));
        else
          write_pixel(IDX_W'($urandom), rand_pixel());
      end
      drain();
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_size();
    test_value_extremes();
    test_size_extremes();
    test_random_traffic();
    drain();
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bws_pkg.sv
rtl/bws_ram.sv
rtl/bws_addr.sv
rtl/bws_lane.sv
rtl/bilinear_wrap_sampler_top.sv
tb/tb_bilinear_wrap_sampler_top.sv
